/* hw/rtl/nss_pkg.sv */
// shared types and constants of the nfa state set stepper
package nss_pkg;

    localparam int MAX_STATES_DEF = 256;

    localparam logic [1:0] CMD_WR_ENTRY = 2'd0;
    localparam logic [1:0] CMD_WR_CLASS = 2'd1;
    localparam logic [1:0] CMD_START    = 2'd2;
    localparam logic [1:0] CMD_STEP     = 2'd3;

    localparam logic [1:0] EDGE_NONE    = 2'd0;
    localparam logic [1:0] EDGE_SINGLE  = 2'd1;
    localparam logic [1:0] EDGE_EPS     = 2'd2;
    localparam logic [1:0] EDGE_CLASS   = 2'd3;

    localparam logic [8:0] USED_RESET   = 9'd256;

    typedef struct packed {
        logic [1:0] anchor;
        logic       accepting;
        logic       second_valid;
        logic [7:0] second;
        logic       first_valid;
        logic [7:0] first;
        logic [7:0] symbol;
        logic [1:0] kind;
    } t_entry;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  state_index;
        logic [1:0]  edge_kind;
        logic [7:0]  symbol;
        logic [7:0]  next_first;
        logic        next_first_valid;
        logic [7:0]  next_second;
        logic        next_second_valid;
        logic        accepting;
        logic [1:0]  anchor_in;
        logic [1:0]  class_word;
        logic [63:0] class_bits;
    } t_item;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_EMPTY,
        RES_CLOSURE
    } t_res_kind;

    typedef struct packed {
        logic      wr_entry;
        logic      wr_class;
        logic      start;
        logic      mv_init;
        logic      mv_step;
        logic      commit;
        logic      cl_pop;
        logic      cl_e1;
        logic      cl_e2;
        logic      load_out;
        t_res_kind res_kind;
    } t_dp_cmd;

    typedef struct packed {
        logic mv_done;
        logic any;
        logic stack_empty;
    } t_dp_sts;

endpackage

/* hw/rtl/nss_if.sv */
// request, result and configuration channel interfaces
interface nss_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [7:0]  state_index;
    logic [1:0]  edge_kind;
    logic [7:0]  symbol;
    logic [7:0]  next_first;
    logic        next_first_valid;
    logic [7:0]  next_second;
    logic        next_second_valid;
    logic        accepting;
    logic [1:0]  anchor_in;
    logic [1:0]  class_word;
    logic [63:0] class_bits;
    modport source (output valid, command, state_index, edge_kind, symbol, next_first,
                    next_first_valid, next_second, next_second_valid, accepting,
                    anchor_in, class_word, class_bits, input ready);
    modport sink (input valid, command, state_index, edge_kind, symbol, next_first,
                  next_first_valid, next_second, next_second_valid, accepting,
                  anchor_in, class_word, class_bits, output ready);
endinterface

interface nss_out_if;
    logic       valid;
    logic       ready;
    logic       set_empty;
    logic       accept_found;
    logic [7:0] accept_state;
    logic [1:0] anchor_out;
    modport source (output valid, set_empty, accept_found, accept_state, anchor_out,
                    input ready);
    modport sink (input valid, set_empty, accept_found, accept_state, anchor_out,
                  output ready);
endinterface

interface nss_cfg_if;
    logic       valid;
    logic       ready;
    logic [8:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

/* hw/rtl/nfa_state_set_stepper_top.sv */
// top level of the nfa state set stepper
//
//  channel   dir   handshake      payload
//  i_in      in    valid/ready    command, state index, entry fields, class word
//  o_out     out   valid/ready    set_empty, accept_found, accept_state, anchor_out
//  i_cfg     in    valid/ready    used_states (9 bits), ready always high
//
// write requests write their memory on acceptance. start runs the closure of the start state.
// step runs the move scan over the first used_states entries (one entry read per cycle
// from the entry and class memories), then the closure, each closure state taking
// a stack pop, an entry read and two successor pushes through one stack port.
// one request is in flight at a time; the result register lets the next request
// enter while a result waits, and a held result stalls only the next completion.
// reset is synchronous, clears the active set and sets used_states to 256.
module nfa_state_set_stepper_top #(
    parameter int MAX_STATES = nss_pkg::MAX_STATES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    nss_in_if.sink       i_in,
    nss_out_if.source    o_out,
    nss_cfg_if.sink      i_cfg
);

    nss_pkg::t_item    item;
    nss_pkg::t_dp_cmd  cmd;
    nss_pkg::t_dp_sts  sts;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        item.command           = i_in.command;
        item.state_index       = i_in.state_index;
        item.edge_kind         = i_in.edge_kind;
        item.symbol            = i_in.symbol;
        item.next_first        = i_in.next_first;
        item.next_first_valid  = i_in.next_first_valid;
        item.next_second       = i_in.next_second;
        item.next_second_valid = i_in.next_second_valid;
        item.accepting         = i_in.accepting;
        item.anchor_in         = i_in.anchor_in;
        item.class_word        = i_in.class_word;
        item.class_bits        = i_in.class_bits;
    end

    nss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_command   (i_in.command),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    nss_dp #(
        .MAX_STATES (MAX_STATES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (item),
        .i_cfg_we       (i_cfg.valid),
        .i_cfg_data     (i_cfg.data),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_set_empty    (o_out.set_empty),
        .o_accept_found (o_out.accept_found),
        .o_accept_state (o_out.accept_state),
        .o_anchor_out   (o_out.anchor_out)
    );

endmodule

/* hw/rtl/nss_ctrl.sv */
// controller state machine sequencing writes, move scan and closure
module nss_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_command,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  nss_pkg::t_dp_sts  i_sts,
    output nss_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOVE,
        S_COMMIT,
        S_POP,
        S_ADDR,
        S_EPS1,
        S_EPS2,
        S_DONE
    } t_state;

    t_state              r_state;
    nss_pkg::t_res_kind  r_kind;
    logic                r_out_valid;
    logic                accept;
    logic                out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign accept      = i_in_valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd          = '0;
        o_cmd.res_kind = r_kind;
        o_cmd.wr_entry = accept && (i_command == nss_pkg::CMD_WR_ENTRY);
        o_cmd.wr_class = accept && (i_command == nss_pkg::CMD_WR_CLASS);
        o_cmd.start    = accept && (i_command == nss_pkg::CMD_START);
        o_cmd.mv_init  = accept && (i_command == nss_pkg::CMD_STEP);
        o_cmd.mv_step  = (r_state == S_MOVE);
        o_cmd.commit   = (r_state == S_COMMIT);
        o_cmd.cl_pop   = (r_state == S_POP) && !i_sts.stack_empty;
        o_cmd.cl_e1    = (r_state == S_EPS1);
        o_cmd.cl_e2    = (r_state == S_EPS2);
        o_cmd.load_out = (r_state == S_DONE) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_kind      <= nss_pkg::RES_ZERO;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        unique case (i_command)
                            nss_pkg::CMD_START: begin
                                r_kind  <= nss_pkg::RES_CLOSURE;
                                r_state <= S_POP;
                            end
                            nss_pkg::CMD_STEP: begin
                                r_state <= S_MOVE;
                            end
                            default: begin
                                r_kind  <= nss_pkg::RES_ZERO;
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_MOVE: begin
                    if (i_sts.mv_done) begin
                        r_state <= S_COMMIT;
                    end
                end
                S_COMMIT: begin
                    if (i_sts.any) begin
                        r_kind  <= nss_pkg::RES_CLOSURE;
                        r_state <= S_POP;
                    end else begin
                        r_kind  <= nss_pkg::RES_EMPTY;
                        r_state <= S_DONE;
                    end
                end
                S_POP: begin
                    r_state <= i_sts.stack_empty ? S_DONE : S_ADDR;
                end
                S_ADDR: r_state <= S_EPS1;
                S_EPS1: r_state <= S_EPS2;
                S_EPS2: r_state <= S_POP;
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* hw/rtl/nss_dp.sv */
// datapath: entry and class memories, state sets, work stack, result register
module nss_dp #(
    parameter int MAX_STATES = nss_pkg::MAX_STATES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  nss_pkg::t_item    i_item,
    input  logic              i_cfg_we,
    input  logic [8:0]        i_cfg_data,
    input  nss_pkg::t_dp_cmd  i_cmd,
    output nss_pkg::t_dp_sts  o_sts,
    output logic              o_set_empty,
    output logic              o_accept_found,
    output logic [7:0]        o_accept_state,
    output logic [1:0]        o_anchor_out
);

    localparam int DEPTH = (MAX_STATES < 256) ? MAX_STATES : 256;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    function automatic logic in_range(input logic [7:0] s);
        in_range = (32'(s) < MAX_STATES);
    endfunction

    nss_pkg::t_entry  entry_mem [DEPTH];
    logic [63:0]      class_mem [4*DEPTH];
    logic [7:0]       stack_mem [DEPTH];

    logic [8:0]       r_used;
    logic [DEPTH-1:0] r_set;
    logic [DEPTH-1:0] r_nxt;
    logic [CW-1:0]    r_scan;
    logic [CW-1:0]    r_top;
    logic             r_pv;
    logic             r_pact;
    logic             r_any;
    logic [7:0]       r_sym;
    nss_pkg::t_entry  r_ent;
    logic [63:0]      r_cls;
    logic [7:0]       r_stk_q;
    logic             r_found;
    logic [7:0]       r_best;
    logic [1:0]       r_anc;

    logic [CW-1:0]    n_eff;
    logic [AW-1:0]    ent_addr;
    logic             hit;
    logic             eps;
    logic             push_v;
    logic [7:0]       push_s;
    nss_pkg::t_entry  wr_ent;
    logic [CW-1:0]    top_dec;

    assign n_eff    = (32'(r_used) > DEPTH) ? CW'(DEPTH) : CW'(r_used);
    assign ent_addr = i_cmd.mv_step ? r_scan[AW-1:0] : r_stk_q[AW-1:0];
    assign top_dec  = r_top - CW'(1);
    assign eps      = (r_ent.kind == nss_pkg::EDGE_EPS);

    assign hit = r_pv && r_pact && r_ent.first_valid && in_range(r_ent.first)
        && (((r_ent.kind == nss_pkg::EDGE_SINGLE) && (r_ent.symbol == r_sym))
            || ((r_ent.kind == nss_pkg::EDGE_CLASS) && r_cls[r_sym[5:0]]));

    assign o_sts.mv_done     = (r_scan == n_eff) && !r_pv;
    assign o_sts.any         = r_any;
    assign o_sts.stack_empty = (r_top == '0);

    always_comb begin
        wr_ent.kind         = i_item.edge_kind;
        wr_ent.symbol       = i_item.symbol;
        wr_ent.first        = i_item.next_first;
        wr_ent.first_valid  = i_item.next_first_valid;
        wr_ent.second       = i_item.next_second;
        wr_ent.second_valid = i_item.next_second_valid;
        wr_ent.accepting    = i_item.accepting;
        wr_ent.anchor       = i_item.anchor_in;
    end

    // one push per cycle: move target, closure successor or start state
    always_comb begin
        push_v = 1'b0;
        push_s = r_ent.first;
        if (i_cmd.start) begin
            push_s = i_item.state_index;
            push_v = in_range(i_item.state_index);
        end else if (i_cmd.mv_step) begin
            push_v = hit && !r_nxt[r_ent.first[AW-1:0]];
        end else if (i_cmd.cl_e1) begin
            push_v = eps && r_ent.first_valid && in_range(r_ent.first)
                && !r_set[r_ent.first[AW-1:0]];
        end else if (i_cmd.cl_e2) begin
            push_s = r_ent.second;
            push_v = eps && r_ent.second_valid && in_range(r_ent.second)
                && !r_set[r_ent.second[AW-1:0]];
        end
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_entry && in_range(i_item.state_index)) begin
            entry_mem[i_item.state_index[AW-1:0]] <= wr_ent;
        end
        if (i_cmd.wr_class && in_range(i_item.state_index)) begin
            class_mem[{i_item.state_index[AW-1:0], i_item.class_word}] <= i_item.class_bits;
        end
        if (push_v) begin
            stack_mem[i_cmd.start ? '0 : r_top[AW-1:0]] <= push_s;
        end
        r_ent <= entry_mem[ent_addr];
        r_cls <= class_mem[{r_scan[AW-1:0], r_sym[7:6]}];
        if (i_cmd.cl_pop) begin
            r_stk_q <= stack_mem[top_dec[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mv_init) begin
            r_sym <= i_item.symbol;
        end
        if (i_cmd.cl_e1 && r_ent.accepting && (!r_found || (r_stk_q < r_best))) begin
            r_best <= r_stk_q;
            r_anc  <= r_ent.anchor;
        end
        if (i_cmd.load_out) begin
            o_set_empty    <= (i_cmd.res_kind == nss_pkg::RES_EMPTY);
            o_accept_found <= (i_cmd.res_kind == nss_pkg::RES_CLOSURE) && r_found;
            o_accept_state <= ((i_cmd.res_kind == nss_pkg::RES_CLOSURE) && r_found)
                              ? r_best : 8'd0;
            o_anchor_out   <= ((i_cmd.res_kind == nss_pkg::RES_CLOSURE) && r_found)
                              ? r_anc : 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= nss_pkg::USED_RESET;
            r_set   <= '0;
            r_nxt   <= '0;
            r_scan  <= '0;
            r_top   <= '0;
            r_pv    <= 1'b0;
            r_pact  <= 1'b0;
            r_any   <= 1'b0;
            r_found <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_used <= i_cfg_data;
            end
            if (i_cmd.start) begin
                r_set   <= push_v ? (DEPTH'(1) << i_item.state_index[AW-1:0]) : '0;
                r_found <= 1'b0;
            end
            if (i_cmd.mv_init) begin
                r_nxt   <= '0;
                r_scan  <= '0;
                r_pv    <= 1'b0;
                r_any   <= 1'b0;
                r_found <= 1'b0;
            end
            if (i_cmd.mv_step) begin
                if (hit) begin
                    r_any <= 1'b1;
                    r_nxt[r_ent.first[AW-1:0]] <= 1'b1;
                end
                // issue the next entry read while the previous one is evaluated
                if (r_scan != n_eff) begin
                    r_pv   <= 1'b1;
                    r_pact <= r_set[r_scan[AW-1:0]];
                    r_scan <= r_scan + CW'(1);
                end else begin
                    r_pv <= 1'b0;
                end
            end
            if (i_cmd.commit) begin
                r_set <= r_nxt;
            end
            if (i_cmd.cl_e1 && r_ent.accepting) begin
                r_found <= 1'b1;
            end
            if ((i_cmd.cl_e1 || i_cmd.cl_e2) && push_v) begin
                r_set[push_s[AW-1:0]] <= 1'b1;
            end
            if (i_cmd.start) begin
                r_top <= push_v ? CW'(1) : '0;
            end else if (i_cmd.mv_init) begin
                r_top <= '0;
            end else if (push_v) begin
                r_top <= r_top + CW'(1);
            end else if (i_cmd.cl_pop) begin
                r_top <= top_dec;
            end
        end
    end

endmodule

/* bench/tb_nfa_state_set_stepper_top.sv */
// testbench of the nfa state set stepper: random nfa tables, start and step requests
`timescale 1ns / 100ps

typedef struct {
    bit       set_empty;
    bit       accept_found;
    bit [7:0] accept_state;
    bit [1:0] anchor_out;
} t_nfa_res;

class nss_scoreboard;
    nss_pkg::t_entry entries[256];
    logic [63:0]     class_words[1024];
    bit [255:0]      active;
    int unsigned     used_states;
    t_nfa_res        pending_res[$];
    int              errors;

    function new();
        active = '0;
        used_states = 256;
        errors = 0;
    endfunction

    // grow the active set to its epsilon closure, report lowest accepting state
    function t_nfa_res close_active();
        int stk[$];
        int k;
        nss_pkg::t_entry e;
        t_nfa_res r;
        r = '{default: 0};
        for (k = 0; k < 256; k++) if (active[k]) stk.push_back(k);
        while (stk.size() > 0) begin
            k = stk.pop_back();
            e = entries[k];
            if (e.kind == nss_pkg::EDGE_EPS) begin
                if (e.first_valid && !active[e.first]) begin
                    active[e.first] = 1'b1;
                    stk.push_back(int'(e.first));
                end
                if (e.second_valid && !active[e.second]) begin
                    active[e.second] = 1'b1;
                    stk.push_back(int'(e.second));
                end
            end
        end
        for (k = 0; k < 256; k++) begin
            if (active[k] && entries[k].accepting) begin
                r.accept_found = 1'b1;
                r.accept_state = k[7:0];
                r.anchor_out = entries[k].anchor;
                break;
            end
        end
        return r;
    endfunction

    function void note_request(nss_pkg::t_item it);
        t_nfa_res r;
        bit [255:0] moved;
        bit any;
        int k;
        nss_pkg::t_entry e;
        bit hit;
        r = '{default: 0};
        case (it.command)
            nss_pkg::CMD_WR_ENTRY: begin
                entries[it.state_index] = '{anchor: it.anchor_in, accepting: it.accepting,
                    second_valid: it.next_second_valid, second: it.next_second,
                    first_valid: it.next_first_valid, first: it.next_first,
                    symbol: it.symbol, kind: it.edge_kind};
            end
            nss_pkg::CMD_WR_CLASS: class_words[{it.state_index, it.class_word}] = it.class_bits;
            nss_pkg::CMD_START: begin
                active = '0;
                active[it.state_index] = 1'b1;
                r = close_active();
            end
            default: begin
                moved = '0;
                any = 1'b0;
                for (k = 0; k < used_states && k < 256; k++) begin
                    if (!active[k]) continue;
                    e = entries[k];
                    hit = (e.kind == nss_pkg::EDGE_SINGLE && e.symbol == it.symbol) ||
                          (e.kind == nss_pkg::EDGE_CLASS &&
                           class_words[{k[7:0], it.symbol[7:6]}][it.symbol[5:0]]);
                    if (hit && e.first_valid) begin
                        moved[e.first] = 1'b1;
                        any = 1'b1;
                    end
                end
                active = moved;
                if (!any) r.set_empty = 1'b1;
                else r = close_active();
            end
        endcase
        pending_res.push_back(r);
    endfunction

    function void check_result(t_nfa_res got);
        t_nfa_res w;
        if (pending_res.size() == 0) begin
            $error("result with no request waiting");
            errors++;
            return;
        end
        w = pending_res.pop_front();
        if (got.set_empty !== w.set_empty) begin
            $error("set_empty expected %0d actual %0d", w.set_empty, got.set_empty);
            errors++;
        end
        if (got.accept_found !== w.accept_found) begin
            $error("accept_found expected %0d actual %0d", w.accept_found, got.accept_found);
            errors++;
        end
        if (got.accept_state !== w.accept_state) begin
            $error("accept_state expected %0d actual %0d", w.accept_state, got.accept_state);
            errors++;
        end
        if (got.anchor_out !== w.anchor_out) begin
            $error("anchor_out expected %0d actual %0d", w.anchor_out, got.anchor_out);
            errors++;
        end
    endfunction
endclass

module tb_nfa_state_set_stepper_top;

    localparam int CYCLE_LIMIT = 10000000;
    localparam int ITEM_TARGET = 1350;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #10 i_clk = ~i_clk;

    nss_in_if  in_ch();
    nss_out_if out_ch();
    nss_cfg_if cfg_ch();

    nfa_state_set_stepper_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    nss_scoreboard sb = new();

    bit       ent_ok[256];
    bit [3:0] cls_mask[256];
    int       written[$];
    int       sent = 0;
    int       burst_left = 0;
    int       cycles = 0;
    bit       hold = 1'b0;
    int       rcv_mode = 0;
    int       rcv_cnt = 0;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("** nfa_state_set_stepper_top: FAILED **");
            $finish;
        end
    end

    // receiver stall pattern: always ready, randomly ready or rarely ready, in changing modes
    always @(negedge i_clk) begin
        bit r;
        if (rcv_cnt == 0) begin
            rcv_mode = $urandom_range(0, 2);
            rcv_cnt = $urandom_range(20, 200);
        end else begin
            rcv_cnt--;
        end
        case (rcv_mode)
            0: r = 1'b1;
            1: r = 1'($urandom_range(0, 1));
            default: r = ($urandom_range(0, 7) == 0);
        endcase
        out_ch.ready = !hold && r;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_result('{out_ch.set_empty, out_ch.accept_found,
                              out_ch.accept_state, out_ch.anchor_out});
    end

    // one long receiver hold-off so the block backs up into its input
    initial begin
        wait (sent >= 400);
        @(negedge i_clk);
        hold = 1'b1;
        repeat (2500) @(posedge i_clk);
        @(negedge i_clk);
        hold = 1'b0;
    end

    function automatic nss_pkg::t_item rand_item();
        logic [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        return raw[$bits(nss_pkg::t_item)-1:0];
    endfunction

    task automatic send_item(input nss_pkg::t_item it);
        @(negedge i_clk);
        in_ch.valid = 1'b1;
        in_ch.command = it.command;
        in_ch.state_index = it.state_index;
        in_ch.edge_kind = it.edge_kind;
        in_ch.symbol = it.symbol;
        in_ch.next_first = it.next_first;
        in_ch.next_first_valid = it.next_first_valid;
        in_ch.next_second = it.next_second;
        in_ch.next_second_valid = it.next_second_valid;
        in_ch.accepting = it.accepting;
        in_ch.anchor_in = it.anchor_in;
        in_ch.class_word = it.class_word;
        in_ch.class_bits = it.class_bits;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_request(it);
        sent++;
        if (burst_left == 0) begin
            @(negedge i_clk);
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
            burst_left = $urandom_range(0, 30);
        end else begin
            burst_left--;
        end
    endtask

    task automatic wr_entry(input int idx, input logic [1:0] kind, input logic [7:0] sym,
                            input int first, input bit fv, input int second, input bit sv,
                            input bit acc, input logic [1:0] anc);
        nss_pkg::t_item it;
        it = rand_item();
        it.command = nss_pkg::CMD_WR_ENTRY;
        it.state_index = 8'(idx);
        it.edge_kind = kind;
        it.symbol = sym;
        it.next_first = 8'(first);
        it.next_first_valid = fv;
        it.next_second = 8'(second);
        it.next_second_valid = sv;
        it.accepting = acc;
        it.anchor_in = anc;
        send_item(it);
        if (!ent_ok[idx]) written.push_back(idx);
        ent_ok[idx] = 1'b1;
    endtask

    task automatic wr_class(input int idx, input logic [1:0] word, input logic [63:0] bits);
        nss_pkg::t_item it;
        it = rand_item();
        it.command = nss_pkg::CMD_WR_CLASS;
        it.state_index = 8'(idx);
        it.class_word = word;
        it.class_bits = bits;
        send_item(it);
        cls_mask[idx][word] = 1'b1;
    endtask

    task automatic start_at(input int idx);
        nss_pkg::t_item it;
        it = rand_item();
        it.command = nss_pkg::CMD_START;
        it.state_index = 8'(idx);
        send_item(it);
    endtask

    task automatic step_on(input logic [7:0] c);
        nss_pkg::t_item it;
        it = rand_item();
        it.command = nss_pkg::CMD_STEP;
        it.symbol = c;
        send_item(it);
    endtask

    task automatic write_used(input logic [8:0] v);
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (sb.pending_res.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.data = v;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        sb.used_states = 32'(v);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    function automatic logic [63:0] rand_bits();
        logic [63:0] a, b;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        case ($urandom_range(0, 2))
            0: return a;
            1: return a & b;
            default: return a | b;
        endcase
    endfunction

    // random entry for idx, successors drawn from states that are or will be written
    task automatic rand_entry(input int idx, input int pool[$], input logic [7:0] alph[4]);
        logic [1:0] kind;
        bit fv;
        int first;
        kind = 2'($urandom_range(0, 3));
        if (kind == nss_pkg::EDGE_CLASS && cls_mask[idx] != 4'hF) kind = nss_pkg::EDGE_EPS;
        fv = ($urandom_range(0, 5) != 0);
        first = fv ? pool[$urandom_range(0, pool.size() - 1)] : int'($urandom_range(0, 255));
        if ($urandom_range(0, 1)) begin
            wr_entry(idx, kind, alph[$urandom_range(0, 3)], first, fv,
                     pool[$urandom_range(0, pool.size() - 1)], 1'b1,
                     $urandom_range(0, 2) == 0, 2'($urandom_range(0, 3)));
        end else begin
            wr_entry(idx, kind, alph[$urandom_range(0, 3)], first, fv,
                     int'($urandom_range(0, 255)), 1'b0,
                     $urandom_range(0, 2) == 0, 2'($urandom_range(0, 3)));
        end
    endtask

    task automatic run_phase();
        int plan[$];
        int pool[$];
        int k, idx, w;
        logic [7:0] alph[4];
        case ($urandom_range(0, 3))
            0: write_used(9'd1);
            1: write_used(9'($urandom_range(1, 256)));
            default: write_used(9'd256);
        endcase
        for (k = 0; k < 4; k++) alph[k] = 8'($urandom_range(0, 255));
        k = $urandom_range(2, 10);
        while (plan.size() < k) begin
            idx = $urandom_range(0, 255);
            if (!(idx inside {plan})) plan.push_back(idx);
        end
        pool = plan;
        foreach (written[j]) if (!(written[j] inside {plan})) pool.push_back(written[j]);
        foreach (plan[j]) begin
            if ($urandom_range(0, 2) == 0)
                for (w = 0; w < 4; w++) wr_class(plan[j], 2'(w), rand_bits());
        end
        foreach (plan[j]) rand_entry(plan[j], pool, alph);
        repeat ($urandom_range(1, 3)) begin
            start_at(plan[$urandom_range(0, plan.size() - 1)]);
            repeat ($urandom_range(4, 14)) begin
                case ($urandom_range(0, 15))
                    0: wr_class($urandom_range(0, 255), 2'($urandom_range(0, 3)), rand_bits());
                    1: rand_entry($urandom_range(0, 255), written, alph);
                    2: start_at(written[$urandom_range(0, written.size() - 1)]);
                    3, 4: step_on(8'($urandom_range(0, 255)));
                    default: step_on(alph[$urandom_range(0, 3)]);
                endcase
            end
        end
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.command = nss_pkg::CMD_WR_ENTRY;
        in_ch.state_index = '0;
        in_ch.edge_kind = nss_pkg::EDGE_NONE;
        in_ch.symbol = '0;
        in_ch.next_first = '0;
        in_ch.next_first_valid = 1'b0;
        in_ch.next_second = '0;
        in_ch.next_second_valid = 1'b0;
        in_ch.accepting = 1'b0;
        in_ch.anchor_in = '0;
        in_ch.class_word = '0;
        in_ch.class_bits = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // top state with a class edge, all-ones top quarter, empty bottom quarter
        wr_class(255, 2'd0, 64'h0);
        wr_class(255, 2'd1, rand_bits());
        wr_class(255, 2'd2, rand_bits());
        wr_class(255, 2'd3, 64'hFFFF_FFFF_FFFF_FFFF);
        wr_entry(255, nss_pkg::EDGE_CLASS, 8'hFF, 0, 1'b1, 255, 1'b1, 1'b1, 2'd3);
        wr_entry(0, nss_pkg::EDGE_EPS, 8'h00, 255, 1'b1, 0, 1'b1, 1'b1, 2'd1);
        wr_entry(1, nss_pkg::EDGE_SINGLE, 8'hA5, 2, 1'b1, 0, 1'b0, 1'b0, 2'd0);
        wr_entry(2, nss_pkg::EDGE_NONE, 8'h00, 0, 1'b0, 0, 1'b0, 1'b1, 2'd2);
        // matching edge without successor
        wr_entry(3, nss_pkg::EDGE_SINGLE, 8'h00, 0, 1'b0, 0, 1'b0, 1'b0, 2'd0);
        start_at(1);
        step_on(8'hA5);
        step_on(8'h00);
        start_at(255);
        step_on(8'hFF);     // tie in the closure: state 0 beats 255
        step_on(8'h00);
        start_at(3);
        step_on(8'h00);
        write_used(9'd1);
        start_at(255);
        step_on(8'hFF);     // state 255 lies outside the scan
        start_at(0);
        step_on(8'hFF);
        write_used(9'd256);

        while (sent < ITEM_TARGET) run_phase();

        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (sb.pending_res.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("** nfa_state_set_stepper_top: PASSED **");
        end else begin
            $display("** nfa_state_set_stepper_top: FAILED **");
        end
        $finish;
    end
endmodule
